[rtl/periodic_nearest_point_search_core_assert.svh]
// Assertion macros for the checker file of this block.
`ifndef PERIODIC_NEAREST_POINT_SEARCH_CORE_ASSERT_SVH
`define PERIODIC_NEAREST_POINT_SEARCH_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define PNPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PNPS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/pnps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pnps_pkg;

	// Register indexes on the configuration port (address bits [5:3]).
	localparam logic [2:0] REG_PERIOD_X      = 3'd0;
	localparam logic [2:0] REG_PERIOD_Y      = 3'd1;
	localparam logic [2:0] REG_PERIOD_Z      = 3'd2;
	localparam logic [2:0] REG_NODE_COUNT    = 3'd3;
	localparam logic [2:0] REG_BAD_THRESHOLD = 3'd4;

	localparam logic [6:0]  NODE_COUNT_RST    = 7'd64;
	localparam logic [63:0] BAD_THRESHOLD_RST = 64'd4294967;

	localparam logic [0:0] REQ_LOAD  = 1'b0;
	localparam logic [0:0] REQ_QUERY = 1'b1;

	// One table entry as stored in the candidate memory.
	typedef struct packed {
		logic [15:0] node;
		logic [31:0] z;
		logic [31:0] y;
		logic [31:0] x;
	} pnps_cand_t;

	// Control that travels with a slot through the distance pipeline.
	typedef struct packed {
		logic valid;
		logic last;
	} pnps_tag_t;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? {64{1'b1}} : s[63:0];
	endfunction

endpackage

`default_nettype wire

[rtl/pnps_eval.sv]
`timescale 1ns / 1ps
`default_nettype none

// Eight-stage distance pipeline: one candidate slot enters per cycle, and the
// smallest of its eight shifted squared distances leaves the last stage.
module pnps_eval
	import pnps_pkg::*;
#(
	parameter int AW = 6
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pnps_tag_t       in_tag,
	input  wire logic [AW-1:0]   in_slot,
	input  wire pnps_cand_t      cand,
	input  wire logic [31:0]     tgt_x,
	input  wire logic [31:0]     tgt_y,
	input  wire logic [31:0]     tgt_z,
	input  wire logic [30:0]     period_x,
	input  wire logic [30:0]     period_y,
	input  wire logic [30:0]     period_z,
	output pnps_tag_t            out_tag,
	output logic [AW-1:0]        out_slot,
	output logic [15:0]          out_node,
	output logic [63:0]          out_dist
);

	pnps_tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7, tag_s8;
	logic [AW-1:0] slot_s1, slot_s2, slot_s3, slot_s4, slot_s5, slot_s6, slot_s7, slot_s8;
	logic [15:0] node_s1, node_s2, node_s3, node_s4, node_s5, node_s6, node_s7, node_s8;

	// Axis order is x, y, z; entry 2*axis+s holds the value for shift bit s.
	logic [32:0] ad_s1 [3];
	logic [31:0] mag_s2 [6];
	logic        sat_s2 [6];
	logic [63:0] sq_s3 [6];
	logic [63:0] xy_s4 [4];
	logic [63:0] z_s4 [2];
	logic [63:0] d_s5 [8];
	logic [63:0] l1_s6 [4];
	logic [63:0] l2_s7 [2];
	logic [63:0] l3_s8;

	logic [31:0] tgt [3];
	logic [31:0] pos [3];
	logic [30:0] per [3];
	logic [32:0] diff [3];
	logic [33:0] rem [3];
	logic [33:0] rem_abs [3];

	always_comb begin
		tgt[0] = tgt_x;
		tgt[1] = tgt_y;
		tgt[2] = tgt_z;
		pos[0] = cand.x;
		pos[1] = cand.y;
		pos[2] = cand.z;
		per[0] = period_x;
		per[1] = period_y;
		per[2] = period_z;
		for (int a = 0; a < 3; a++) begin
			diff[a] = {tgt[a][31], tgt[a]} - {pos[a][31], pos[a]};
			rem[a] = {1'b0, ad_s1[a]} - {3'b000, per[a]};
			rem_abs[a] = rem[a][33] ? (~rem[a] + 34'd1) : rem[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
			tag_s6 <= '0;
			tag_s7 <= '0;
			tag_s8 <= '0;
		end else begin
			tag_s1 <= in_tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
			tag_s7 <= tag_s6;
			tag_s8 <= tag_s7;
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= in_slot;
		slot_s2 <= slot_s1;
		slot_s3 <= slot_s2;
		slot_s4 <= slot_s3;
		slot_s5 <= slot_s4;
		slot_s6 <= slot_s5;
		slot_s7 <= slot_s6;
		slot_s8 <= slot_s7;
		node_s1 <= cand.node;
		node_s2 <= node_s1;
		node_s3 <= node_s2;
		node_s4 <= node_s3;
		node_s5 <= node_s4;
		node_s6 <= node_s5;
		node_s7 <= node_s6;
		node_s8 <= node_s7;

		for (int a = 0; a < 3; a++) begin
			ad_s1[a] <= diff[a][32] ? (~diff[a] + 33'd1) : diff[a];
			// Without a shift the magnitude is the distance itself.
			mag_s2[2*a]   <= ad_s1[a][31:0];
			sat_s2[2*a]   <= ad_s1[a][32];
			mag_s2[2*a+1] <= rem_abs[a][31:0];
			sat_s2[2*a+1] <= |rem_abs[a][33:32];
		end

		for (int i = 0; i < 6; i++) begin
			sq_s3[i] <= sat_s2[i] ? {64{1'b1}} : (64'(mag_s2[i]) * 64'(mag_s2[i]));
		end

		for (int k = 0; k < 4; k++) begin
			xy_s4[k] <= sat_add(sq_s3[k % 2], sq_s3[2 + k / 2]);
		end
		z_s4[0] <= sq_s3[4];
		z_s4[1] <= sq_s3[5];

		for (int c = 0; c < 8; c++) begin
			d_s5[c] <= sat_add(xy_s4[c % 4], z_s4[c / 4]);
		end

		// The later combination wins only when strictly smaller.
		for (int i = 0; i < 4; i++) begin
			l1_s6[i] <= (d_s5[2*i+1] < d_s5[2*i]) ? d_s5[2*i+1] : d_s5[2*i];
		end
		for (int i = 0; i < 2; i++) begin
			l2_s7[i] <= (l1_s6[2*i+1] < l1_s6[2*i]) ? l1_s6[2*i+1] : l1_s6[2*i];
		end
		l3_s8 <= (l2_s7[1] < l2_s7[0]) ? l2_s7[1] : l2_s7[0];
	end

	assign out_tag  = tag_s8;
	assign out_slot = slot_s8;
	assign out_node = node_s8;
	assign out_dist = l3_s8;

endmodule

`default_nettype wire

[rtl/periodic_nearest_point_search_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser: req_type; tdata: load or query point
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: match node, slot, distance, flag
// apb       in         psel, penable, pwrite / pready register writes and reads
//
// A load request writes one slot of the candidate memory.
// A query request passes through one memory read per slot, the eight stages
// of distance pipeline, the running minimum and the output register.
// The sequential scan of the candidate memory sets the query length.
// After reset the block is idle and ready; memory contents are undefined.
// A result that waits on m_axis_tready holds the output, yet the next request
// is taken as soon as the search that produced it has finished.

module periodic_nearest_point_search_core
	import pnps_pkg::*;
#(
	parameter int MAX_NODES = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_axis_tvalid,
	output logic               s_axis_tready,
	// [5:0] slot, [37:6] coord_x, [69:38] coord_y, [101:70] coord_z,
	// [117:102] node_id, [119:118] zero
	input  wire logic [119:0]  s_axis_tdata,
	// [0] req_type
	input  wire logic [0:0]    s_axis_tuser,
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	// [15:0] match_node, [21:16] match_slot, [85:22] min_dist_sq,
	// [86] bad_match, [87] zero
	output logic [87:0]        m_axis_tdata,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [5:0]    paddr,
	input  wire logic [63:0]   pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);

	// Address width of the table, count width, widths used for compares, and the output slot width.
	localparam int AW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CW    = $clog2(MAX_NODES + 1);
	localparam int KW    = (CW > 7) ? CW : 7;
	localparam int SW    = (AW > 6) ? AW + 1 : 7;
	localparam int SLOTW = (AW > 6) ? AW : 6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	// Configuration registers.
	logic [30:0] period_x_q, period_y_q, period_z_q;
	logic [6:0]  node_count_q;
	logic [63:0] bad_threshold_q;

	logic [2:0] reg_idx;
	logic       cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_x_q      <= '0;
			period_y_q      <= '0;
			period_z_q      <= '0;
			node_count_q    <= NODE_COUNT_RST;
			bad_threshold_q <= BAD_THRESHOLD_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_PERIOD_X:      period_x_q      <= pwdata[30:0];
				REG_PERIOD_Y:      period_y_q      <= pwdata[30:0];
				REG_PERIOD_Z:      period_z_q      <= pwdata[30:0];
				REG_NODE_COUNT:    node_count_q    <= pwdata[6:0];
				REG_BAD_THRESHOLD: bad_threshold_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PERIOD_X:      prdata = {33'd0, period_x_q};
			REG_PERIOD_Y:      prdata = {33'd0, period_y_q};
			REG_PERIOD_Z:      prdata = {33'd0, period_z_q};
			REG_NODE_COUNT:    prdata = {57'd0, node_count_q};
			REG_BAD_THRESHOLD: prdata = bad_threshold_q;
			default:           prdata = '0;
		endcase
	end

	// Request fields.
	logic       in_req;
	logic [5:0] in_slot;
	logic [31:0] in_x, in_y, in_z;
	logic [15:0] in_node;
	logic        in_fire;

	assign in_req  = s_axis_tuser[0];
	assign in_slot = s_axis_tdata[5:0];
	assign in_x    = s_axis_tdata[37:6];
	assign in_y    = s_axis_tdata[69:38];
	assign in_z    = s_axis_tdata[101:70];
	assign in_node = s_axis_tdata[117:102];
	assign in_fire = s_axis_tvalid && s_axis_tready;

	// Candidate memory: written by loads, read once per cycle during a scan.
	pnps_cand_t  cand_mem [MAX_NODES];
	pnps_cand_t  cand_rd_q;
	pnps_cand_t  cand_wr;
	logic        mem_we;
	logic [AW-1:0] rd_idx_q;

	assign cand_wr = '{node: in_node, z: in_z, y: in_y, x: in_x};
	assign mem_we  = in_fire && (in_req == REQ_LOAD) && (SW'(in_slot) < SW'(MAX_NODES));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cand_mem[AW'(in_slot)] <= cand_wr;
		end
		cand_rd_q <= cand_mem[rd_idx_q];
	end

	// Effective count: zero counts as one, anything above the table is clipped.
	logic [KW-1:0] count_ext;
	logic [KW-1:0] count_eff;

	assign count_ext = KW'(node_count_q);
	always_comb begin
		priority if (count_ext == '0) begin
			count_eff = KW'(1);
		end else if (count_ext > KW'(MAX_NODES)) begin
			count_eff = KW'(MAX_NODES);
		end else begin
			count_eff = count_ext;
		end
	end

	// Query target, held for the whole scan.
	logic [31:0] tgt_x_q, tgt_y_q, tgt_z_q;
	logic [AW-1:0] last_idx_q;

	always_ff @(posedge clk) begin
		if (in_fire && in_req == REQ_QUERY) begin
			tgt_x_q    <= in_x;
			tgt_y_q    <= in_y;
			tgt_z_q    <= in_z;
			last_idx_q <= AW'(count_eff - KW'(1));
		end
	end

	// The tag of the slot being read lines up with the registered read data.
	state_t        state_q;
	pnps_tag_t     tag_s0;
	logic [AW-1:0] slot_s0;
	logic          scan_last;

	assign scan_last = (rd_idx_q == last_idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s0 <= '0;
		end else begin
			tag_s0.valid <= (state_q == ST_SCAN);
			tag_s0.last  <= (state_q == ST_SCAN) && scan_last;
		end
	end

	always_ff @(posedge clk) begin
		slot_s0 <= rd_idx_q;
	end

	pnps_tag_t     ev_tag;
	logic [AW-1:0] ev_slot;
	logic [15:0]   ev_node;
	logic [63:0]   ev_dist;

	pnps_eval #(
		.AW (AW)
	) u_eval (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_tag   (tag_s0),
		.in_slot  (slot_s0),
		.cand     (cand_rd_q),
		.tgt_x    (tgt_x_q),
		.tgt_y    (tgt_y_q),
		.tgt_z    (tgt_z_q),
		.period_x (period_x_q),
		.period_y (period_y_q),
		.period_z (period_z_q),
		.out_tag  (ev_tag),
		.out_slot (ev_slot),
		.out_node (ev_node),
		.out_dist (ev_dist)
	);

	// Running minimum across slots. The first slot is always taken; a later
	// slot replaces the match only with a strictly smaller distance.
	logic          first_q;
	logic          fin_q;
	logic [63:0]   best_q;
	logic [15:0]   best_node_q;
	logic [AW-1:0] best_slot_q;
	logic          take;
	logic          out_load;

	assign take     = ev_tag.valid && (first_q || ev_dist < best_q);
	assign out_load = (state_q == ST_DRAIN) && fin_q && (!m_axis_tvalid || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			if (in_fire && in_req == REQ_QUERY) begin
				first_q <= 1'b1;
				fin_q   <= 1'b0;
			end else if (ev_tag.valid) begin
				first_q <= 1'b0;
				if (ev_tag.last) begin
					fin_q <= 1'b1;
				end
			end else if (out_load) begin
				fin_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_q      <= ev_dist;
			best_node_q <= ev_node;
			best_slot_q <= ev_slot;
		end
	end

	logic [SLOTW-1:0] best_slot_wide;
	assign best_slot_wide = SLOTW'(best_slot_q);

	// Sequencer with the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rd_idx_q      <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					rd_idx_q <= '0;
					if (in_fire && in_req == REQ_QUERY) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					if (out_load) begin
						m_axis_tdata  <= {1'b0, (best_q > bad_threshold_q), best_q,
							best_slot_wide[5:0], best_node_q};
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// A new result takes the register; otherwise a taken one leaves it.
			if (out_load) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);

endmodule

`default_nettype wire

[rtl/pnps_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "periodic_nearest_point_search_core_assert.svh"

// Port-level checks of the search core.
module pnps_chk (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic [0:0]   s_axis_tuser,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [87:0]  m_axis_tdata
);

	// A result that is not taken stays put.
	`PNPS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

	// A query occupies the block, so no request is taken in the next cycle.
	`PNPS_ASSERT(a_query_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |=> !s_axis_tready, "request taken right after a query")

	// A load leaves the block ready again in the next cycle.
	`PNPS_ASSERT(a_load_fast, s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] |=> s_axis_tready, "load did not complete in one cycle")

	// A new result appears exactly when the search ends and the block frees up.
	`PNPS_ASSERT(a_result_idle, $rose(m_axis_tvalid) |-> s_axis_tready, "result shown while still searching")

endmodule

bind periodic_nearest_point_search_core pnps_chk u_pnps_chk (.*);

`default_nettype wire

[tb/sv/nearest_match_pkg.sv]
`timescale 1ns / 1ps

package nearest_match_pkg;
	import pnps_pkg::*;

	localparam int TABLE_DEPTH = 64;

	typedef struct packed {
		logic [0:0]  kind;
		logic [5:0]  slot;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [15:0] node;
	} point_request_t;

	typedef struct packed {
		logic [15:0] node;
		logic [5:0]  slot;
		logic [63:0] dist_sq;
		logic        bad;
	} match_t;

	class match_tracker;
		logic [31:0] cand_x [TABLE_DEPTH];
		logic [31:0] cand_y [TABLE_DEPTH];
		logic [31:0] cand_z [TABLE_DEPTH];
		logic [15:0] cand_node [TABLE_DEPTH];
		logic [30:0] period [3];
		logic [6:0]  node_count;
		logic [63:0] bad_threshold;
		match_t      expected_matches [$];
		int          errors;

		function new();
			foreach (cand_x[i]) begin
				cand_x[i] = '0;
				cand_y[i] = '0;
				cand_z[i] = '0;
				cand_node[i] = '0;
			end
			foreach (period[i]) period[i] = '0;
			node_count = NODE_COUNT_RST;
			bad_threshold = BAD_THRESHOLD_RST;
			errors = 0;
		endfunction

		function void set_register(logic [2:0] index, logic [63:0] value);
			case (index)
			REG_PERIOD_X: period[0] = value[30:0];
			REG_PERIOD_Y: period[1] = value[30:0];
			REG_PERIOD_Z: period[2] = value[30:0];
			REG_NODE_COUNT: node_count = value[6:0];
			REG_BAD_THRESHOLD: bad_threshold = value;
			default: ;
			endcase
		endfunction

		// Number of slots a query walks, after clamping the register.
		function int searched_slots();
			if (node_count == 0)
				return 1;
			if (node_count > TABLE_DEPTH)
				return TABLE_DEPTH;
			return node_count;
		endfunction

		// Square of (|a - b| - shift), all ones when that exceeds 32 bits; the difference is exact in 64-bit arithmetic.
		function logic [63:0] axis_sq(logic [31:0] a, logic [31:0] b, logic [30:0] shift);
			longint gap;
			logic [63:0] mag;
			gap = longint'($signed(a)) - longint'($signed(b));
			if (gap < 0)
				gap = -gap;
			gap = gap - longint'(shift);
			if (gap < 0)
				gap = -gap;
			mag = gap;
			if (mag > 64'hFFFF_FFFF)
				return '1;
			return mag * mag;
		endfunction

		function logic [63:0] clamp_sum(logic [63:0] a, logic [63:0] b);
			logic [64:0] total;
			total = {1'b0, a} + {1'b0, b};
			return total[64] ? '1 : total[63:0];
		endfunction

		function match_t nearest_match(point_request_t q);
			int count;
			logic [63:0] sx [2];
			logic [63:0] sy [2];
			logic [63:0] sz [2];
			logic [63:0] sum_sq;
			match_t best;
			bit seen_any;
			count = searched_slots();
			best = '0;
			seen_any = 1'b0;
			for (int n = 0; n < count; n++) begin
				sx[0] = axis_sq(q.x, cand_x[n], '0);
				sx[1] = axis_sq(q.x, cand_x[n], period[0]);
				sy[0] = axis_sq(q.y, cand_y[n], '0);
				sy[1] = axis_sq(q.y, cand_y[n], period[1]);
				sz[0] = axis_sq(q.z, cand_z[n], '0);
				sz[1] = axis_sq(q.z, cand_z[n], period[2]);
				for (int zs = 0; zs < 2; zs++)
					for (int ys = 0; ys < 2; ys++)
						for (int xs = 0; xs < 2; xs++) begin
							sum_sq = clamp_sum(clamp_sum(sx[xs], sy[ys]), sz[zs]);
							if (!seen_any || sum_sq < best.dist_sq) begin
								best.node = cand_node[n];
								best.slot = 6'(n);
								best.dist_sq = sum_sq;
								seen_any = 1'b1;
							end
						end
			end
			best.bad = best.dist_sq > bad_threshold;
			return best;
		endfunction

		function void note_request(point_request_t r);
			if (r.kind == REQ_LOAD) begin
				cand_x[r.slot] = r.x;
				cand_y[r.slot] = r.y;
				cand_z[r.slot] = r.z;
				cand_node[r.slot] = r.node;
			end else begin
				expected_matches.push_back(nearest_match(r));
			end
		endfunction

		function void check_result(logic [87:0] beat);
			match_t got;
			match_t want;
			got.node = beat[15:0];
			got.slot = beat[21:16];
			got.dist_sq = beat[85:22];
			got.bad = beat[86];
			if (expected_matches.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: node %h slot %0d dist %h bad %b",
						got.node, got.slot, got.dist_sq, got.bad);
				return;
			end
			want = expected_matches.pop_front();
			if (got.node !== want.node || got.slot !== want.slot ||
				got.dist_sq !== want.dist_sq || got.bad !== want.bad) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected node %h slot %0d dist %h bad %b, got node %h slot %0d dist %h bad %b",
						want.node, want.slot, want.dist_sq, want.bad,
						got.node, got.slot, got.dist_sq, got.bad);
			end
		endfunction

		function int outstanding();
			return expected_matches.size();
		endfunction
	endclass

endpackage

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

// The bench feeds load and query requests into the search core, keeps its own
// copy of the candidate table and registers, and compares every match that
// comes out against the nearest point it computed for the matching query.
module testbench;
	import pnps_pkg::*;
	import nearest_match_pkg::*;

	// An index past the end of the register map; writes to it must be dropped.
	localparam logic [2:0] REG_SPARE = 3'd7;
	// A full query fits within this settle time.
	localparam int SETTLE_CYCLES = 100;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 165;
	localparam int DRAIN_LIMIT = 200000;
	localparam int LONG_HOLD = 400;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	wire          s_axis_tready;
	logic [119:0] s_axis_tdata = '0;
	logic [0:0]   s_axis_tuser = '0;
	wire          m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	wire  [87:0]  m_axis_tdata;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [5:0]   paddr = '0;
	logic [63:0]  pwdata = '0;
	wire  [63:0]  prdata;
	wire          pready;

	// Percent chances that the sender inserts an idle cycle and that the
	// receiver drops tready, set per phase.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	// Cycles left in a forced receiver hold-off; the receiver counts it down.
	int hold_left = 0;

	match_tracker tracker;

	periodic_nearest_point_search_core #(
		.MAX_NODES(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// Hang guard: far beyond the slowest legal run.
	initial begin
		#(64'd30_000_000);
		$display("FAIL periodic_nearest_point_search_core");
		$finish;
	end

	// Result side. Values read right after the edge are the ones the core saw,
	// so a completed handshake is checked here and the next tready is chosen.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				tracker.check_result(m_axis_tdata);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Offers one request and returns at the edge where it was taken. Valid is
	// only dropped when an idle cycle follows, never between two requests.
	task automatic send_request(input point_request_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= r.kind;
		s_axis_tdata <= {2'b00, r.node, r.z, r.y, r.x, r.slot};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		tracker.note_request(r);
	endtask

	// One APB write: setup cycle, then access until pready. Back-to-back
	// writes go straight from access to the next setup.
	task automatic write_register(input logic [2:0] index, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		tracker.set_register(index, value);
	endtask

	task automatic release_bus();
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Stops offering requests and waits until every match is out and any
	// trailing load has certainly finished.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register bits above the field width are filled with noise; the core must
	// ignore them.
	function automatic logic [63:0] with_noise(input logic [63:0] keep, input int width);
		logic [63:0] noisy;
		noisy = {$urandom, $urandom};
		for (int b = 0; b < width; b++)
			noisy[b] = keep[b];
		return noisy;
	endfunction

	task automatic configure(input logic [30:0] px, input logic [30:0] py,
		input logic [30:0] pz, input logic [6:0] count, input logic [63:0] threshold);
		wait_idle();
		write_register(REG_PERIOD_X, with_noise({33'b0, px}, 31));
		write_register(REG_PERIOD_Y, with_noise({33'b0, py}, 31));
		write_register(REG_PERIOD_Z, with_noise({33'b0, pz}, 31));
		write_register(REG_NODE_COUNT, with_noise({57'b0, count}, 7));
		write_register(REG_BAD_THRESHOLD, threshold);
		release_bus();
	endtask

	function automatic point_request_t make_request(input logic [0:0] kind,
		input logic [5:0] slot, input logic [31:0] x, input logic [31:0] y,
		input logic [31:0] z, input logic [15:0] node);
		point_request_t r;
		r.kind = kind;
		r.slot = slot;
		r.x = x;
		r.y = y;
		r.z = z;
		r.node = node;
		return r;
	endfunction

	// Either a full-range coordinate or one in a narrow band around zero.
	function automatic logic [31:0] random_coord();
		if ($urandom_range(0, 2) == 0)
			return $urandom;
		return 32'($urandom_range(0, 32'h003F_FFFF)) - 32'h0020_0000;
	endfunction

	// A coordinate close to an existing one: exact, nudged, or one period away,
	// so the shifted terms and near ties decide the winner.
	function automatic logic [31:0] near_coord(input logic [31:0] c, input logic [30:0] per);
		logic [31:0] nudge;
		nudge = 32'($urandom_range(0, 32'h0001_FFFF)) - 32'h0001_0000;
		case ($urandom_range(0, 3))
		0: return c;
		1: return c + nudge;
		2: return c + {1'b0, per} + (nudge >>> 4);
		default: return c - {1'b0, per} + (nudge >>> 4);
		endcase
	endfunction

	function automatic point_request_t random_request(input int query_pct);
		point_request_t r;
		int lim;
		int pick;
		bit near;
		lim = tracker.searched_slots();
		r.kind = ($urandom_range(0, 99) < query_pct) ? REQ_QUERY : REQ_LOAD;
		r.slot = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, lim - 1));
		r.node = 16'($urandom);
		if (r.kind == REQ_QUERY)
			near = ($urandom_range(0, 3) != 0);
		else
			near = ($urandom_range(0, 2) == 0);
		if (near) begin
			pick = $urandom_range(0, lim - 1);
			r.x = near_coord(tracker.cand_x[pick], tracker.period[0]);
			r.y = near_coord(tracker.cand_y[pick], tracker.period[1]);
			r.z = near_coord(tracker.cand_z[pick], tracker.period[2]);
		end else begin
			r.x = random_coord();
			r.y = random_coord();
			r.z = random_coord();
		end
		return r;
	endfunction

	function automatic logic [30:0] random_period();
		if ($urandom_range(0, 1) == 0)
			return 31'($urandom);
		return 31'($urandom_range(0, 32'h0010_0000));
	endfunction

	initial begin
		logic [30:0] px;
		logic [30:0] py;
		logic [30:0] pz;
		logic [6:0] count;
		logic [63:0] threshold;
		int guard;

		tracker = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Only slots 0 to 3 are read until the whole table has
		// been filled, so the search count is lowered first. Periods and the
		// threshold keep their reset values for the first queries.
		write_register(REG_NODE_COUNT, 64'd4);
		release_bus();
		send_request(make_request(REQ_LOAD, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'hFFFF));
		send_request(make_request(REQ_LOAD, 6'd1, 32'h8000_0000, 32'h7FFF_FFFF,
			32'hFFFF_FFFF, 16'h0000));
		send_request(make_request(REQ_LOAD, 6'd2, 32'h0001_0000, 32'hFFFF_0000,
			32'h0000_8000, 16'h1234));
		// Same point in a later slot: the earlier slot must keep the tie.
		send_request(make_request(REQ_LOAD, 6'd3, 32'h0001_0000, 32'hFFFF_0000,
			32'h0000_8000, 16'hABCD));
		send_request(make_request(REQ_LOAD, 6'd63, 32'h0, 32'h0, 32'h0, 16'h5A5A));
		send_request(make_request(REQ_QUERY, 6'd63, 32'h0001_0000, 32'hFFFF_0000,
			32'h0000_8000, 16'hFFFF));
		send_request(make_request(REQ_QUERY, 6'd0, 32'h0001_0001, 32'hFFFF_0000,
			32'h0000_8000, 16'h0));
		send_request(make_request(REQ_QUERY, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 16'h0));
		send_request(make_request(REQ_QUERY, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'h0));

		// A single slot, with a target so far away that the sum saturates.
		wait_idle();
		write_register(REG_NODE_COUNT, 64'd1);
		release_bus();
		send_request(make_request(REQ_QUERY, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 16'h0));
		send_request(make_request(REQ_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 16'h0));

		// A zero count still searches slot 0.
		wait_idle();
		write_register(REG_NODE_COUNT, 64'd0);
		release_bus();
		send_request(make_request(REQ_QUERY, 6'd0, $urandom, $urandom, $urandom, 16'h0));

		// Widest periods on x and z, a threshold that never trips, and a write to an
		// index past the register map that must change nothing.
		configure(31'h7FFF_FFFF, 31'h0001_0000, 31'h7FFF_FFFF, 7'd4, '1);
		write_register(REG_SPARE, {$urandom, $urandom});
		release_bus();
		send_request(make_request(REQ_QUERY, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 16'h0));
		send_request(make_request(REQ_QUERY, 6'd0, 32'h0002_0000, 32'hFFFE_0000,
			32'h0000_8000, 16'h0));
		send_request(make_request(REQ_QUERY, 6'd0, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_8000, 16'h0));

		// Zero threshold: an exact hit is not flagged, one step off is.
		wait_idle();
		write_register(REG_BAD_THRESHOLD, 64'd0);
		release_bus();
		send_request(make_request(REQ_QUERY, 6'd0, 32'h0001_0000, 32'hFFFF_0000,
			32'h0000_8000, 16'h0));
		send_request(make_request(REQ_QUERY, 6'd0, 32'h0001_0000, 32'hFFFF_0001,
			32'h0000_8000, 16'h0));

		// Fill every slot so that any count can be searched from here on.
		wait_idle();
		for (int s = 0; s < TABLE_DEPTH; s++)
			send_request(make_request(REQ_LOAD, 6'(s), random_coord(), random_coord(),
				random_coord(), 16'($urandom)));

		// Random part: each phase picks a register setting and an idling mix.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
			0: begin
				px = '0;
				py = '0;
				pz = '0;
				count = NODE_COUNT_RST;
				threshold = BAD_THRESHOLD_RST;
			end
			1: begin
				px = '1;
				py = '1;
				pz = '1;
				count = '1;
				threshold = '0;
			end
			2: begin
				px = 31'($urandom_range(0, 32'h0010_0000));
				py = 31'($urandom_range(0, 32'h0010_0000));
				pz = 31'($urandom_range(0, 32'h0010_0000));
				count = 7'd0;
				threshold = '1;
			end
			3: begin
				px = 31'($urandom);
				py = 31'($urandom);
				pz = 31'($urandom);
				count = 7'd1;
				threshold = {$urandom, $urandom};
			end
			default: begin
				px = random_period();
				py = random_period();
				pz = random_period();
				count = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(1, 16));
				case ($urandom_range(0, 2))
				0: threshold = {$urandom, $urandom};
				1: threshold = {32'b0, $urandom};
				default: threshold = {44'b0, 20'($urandom)};
				endcase
			end
			endcase
			configure(px, py, pz, count, threshold);

			case (phase % 4)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 86;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 86;
			end
			default: begin
				send_idle_pct = 14;
				recv_stall_pct = 14;
			end
			endcase

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// The receiver blocks for a long stretch while requests keep
				// coming, so the core fills up and holds off its input.
				if (phase == 4 && i == 40)
					hold_left = LONG_HOLD;
				// The sender stops until every pending match has drained.
				if (phase == 5 && i == 80)
					wait_idle();
				send_request(random_request(60));
			end
		end

		s_axis_tvalid <= 1'b0;
		for (guard = 0; tracker.outstanding() != 0 && guard < DRAIN_LIMIT; guard++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.outstanding() != 0) begin
			$display("%0d expected matches never arrived", tracker.outstanding());
			tracker.errors++;
		end
		if (tracker.errors == 0)
			$display("PASS periodic_nearest_point_search_core");
		else
			$display("FAIL periodic_nearest_point_search_core");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/pnps_pkg.sv
rtl/pnps_eval.sv
rtl/periodic_nearest_point_search_core.sv
rtl/pnps_chk.sv
tb/sv/nearest_match_pkg.sv
tb/sv/testbench.sv
